@@ sv/i2cbb_pkg.sv @@
// Package for the bit-level I2C master: request and result structs,
// opcode, phase and register-index codes. No dependencies.
`default_nettype none
package i2cbb_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 10;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_WACK  = 3'd5
	} op_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_BIT_HALF   = 2'd0,
		REG_START_STOP = 2'd1,
		REG_POLL_LIMIT = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_S1       = 4'd1,
		PH_S2       = 4'd2,
		PH_P1       = 4'd3,
		PH_P2       = 4'd4,
		PH_W_LOW    = 4'd5,
		PH_W_HIGH   = 4'd6,
		PH_R_LOW    = 4'd7,
		PH_R_HIGH   = 4'd8,
		PH_RA_LOW   = 4'd9,
		PH_RA_HIGH  = 4'd10,
		PH_A_SETTLE = 4'd11,
		PH_A_POLL   = 4'd12
	} phase_t;

	localparam logic [7:0] BitHalfReset   = 8'd2;
	localparam logic [7:0] StartStopReset = 8'd4;
	localparam logic [9:0] PollLimitReset = 10'd250;
	localparam logic [3:0] BitsPerByte    = 4'd8;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic       send_ack;
		logic       sda_in;
	} cmd_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_ok;
		logic       timed_out;
	} res_t;

endpackage
`default_nettype wire

@@ sv/i2c_bitbang_master_top.sv @@
// Bit-level I2C master, byte commands, SCL/SDA levels as results.
// Depends on i2cbb_pkg.
`default_nettype none
// Usage:
//  - cmd channel (cmd_valid/cmd_ready/cmd): one request per item. In idle,
//    op start/stop/write/read/wait-ack launches a sequence; op tick advances
//    the running sequence by one tick. Commands seen while busy are dropped.
//  - res channel (res_valid/res_ready/res): exactly one result per request,
//    carrying pin levels, busy/done flags, last read byte and ack status.
//  - cfg port (cfg_we/cfg_idx/cfg_wdata): single-cycle write of the three
//    timing registers; write only while no sequence runs.
// Output: each result is registered and appears on res in the cycle after accept.
// Throughput: one request per cycle unless res backs up; the sequencer state
// update is one compare-and-increment of the delay or poll counter, on accept.
// Stall: the result register holds while res_ready is low; cmd_ready is
// high whenever the result register is empty or being drained.
// Reset: sequencer idle, SCL/SDA high and driven, flags and received byte
// cleared, timing registers at 2 / 4 / 250, no result pending.
module i2c_bitbang_master_top (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_ready,
	input  i2cbb_pkg::cmd_t                  cmd,
	output logic                             res_valid,
	input  wire                              res_ready,
	output i2cbb_pkg::res_t                  res,
	input  wire                              cfg_we,
	input  wire [i2cbb_pkg::CfgIdxW-1:0]     cfg_idx,
	input  wire [i2cbb_pkg::CfgDataW-1:0]    cfg_wdata
);
	import i2cbb_pkg::*;

	// timing registers
	logic [7:0] bit_half_q, start_stop_q;
	logic [9:0] poll_limit_q;

	// sequencer state
	phase_t     phase_q, phase_n;
	logic [3:0] bit_cnt_q, bit_cnt_n;
	logic [7:0] shift_q, shift_n;
	logic [7:0] delay_q, delay_n;
	logic [9:0] poll_q, poll_n;
	logic       scl_q, scl_n, sda_q, sda_n, drive_q, drive_n;
	logic       ack_flag_q, ack_flag_n, ack_send_q, ack_send_n;
	logic [7:0] rx_hold_q, rx_hold_n;
	logic       tmo_q, tmo_n;
	logic       done_n;

	logic       res_valid_q;
	res_t       res_q;

	logic       accept;
	logic [7:0] dly_inc, lim_sel;
	logic       elapsed;
	logic [3:0] bit_inc;
	logic [7:0] shift_sh;

	assign cmd_ready = !res_valid_q || res_ready;
	assign accept    = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_half_q   <= BitHalfReset;
			start_stop_q <= StartStopReset;
			poll_limit_q <= PollLimitReset;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_BIT_HALF:   bit_half_q   <= cfg_wdata[7:0];
				REG_START_STOP: start_stop_q <= cfg_wdata[7:0];
				REG_POLL_LIMIT: poll_limit_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// Phase timer: start/stop phases use start_stop_q, bit phases bit_half_q.
	// A zero limit elapses on every tick.
	assign lim_sel  = (phase_q == PH_S1 || phase_q == PH_S2 ||
	                   phase_q == PH_P1 || phase_q == PH_P2) ? start_stop_q : bit_half_q;
	assign dly_inc  = delay_q + 8'd1;
	assign elapsed  = (dly_inc >= lim_sel);
	assign bit_inc  = bit_cnt_q + 4'd1;
	assign shift_sh = {shift_q[6:0], 1'b0};

	always_comb begin
		phase_n    = phase_q;
		bit_cnt_n  = bit_cnt_q;
		shift_n    = shift_q;
		delay_n    = delay_q;
		poll_n     = poll_q;
		scl_n      = scl_q;
		sda_n      = sda_q;
		drive_n    = drive_q;
		ack_flag_n = ack_flag_q;
		ack_send_n = ack_send_q;
		rx_hold_n  = rx_hold_q;
		tmo_n      = tmo_q;
		done_n     = 1'b0;

		if (cmd.op >= OP_START && cmd.op <= OP_WACK) begin
			if (phase_q == PH_IDLE) begin
				delay_n = 8'd0;
				case (op_t'(cmd.op))
					OP_START: begin
						drive_n = 1'b1; scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_S1;
					end
					OP_STOP: begin
						drive_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0; phase_n = PH_P1;
					end
					OP_WRITE: begin
						drive_n = 1'b1; scl_n = 1'b0; bit_cnt_n = 4'd0;
						shift_n = cmd.data_byte; sda_n = cmd.data_byte[7];
						phase_n = PH_W_LOW;
					end
					OP_READ: begin
						drive_n = 1'b0; scl_n = 1'b0; bit_cnt_n = 4'd0; shift_n = 8'd0;
						ack_send_n = cmd.send_ack; phase_n = PH_R_LOW;
					end
					default: begin
						drive_n = 1'b0; scl_n = 1'b1; poll_n = 10'd0;
						ack_flag_n = 1'b0; tmo_n = 1'b0; phase_n = PH_A_SETTLE;
					end
				endcase
			end
		end else if (cmd.op == OP_TICK && phase_q != PH_IDLE) begin
			// shared timer step for every timed phase
			if (phase_q != PH_A_POLL) begin
				delay_n = elapsed ? 8'd0 : dly_inc;
			end
			case (phase_q)
				PH_S1: if (elapsed) begin
					sda_n = 1'b0; phase_n = PH_S2;
				end
				PH_S2: if (elapsed) begin
					scl_n = 1'b0; phase_n = PH_IDLE; done_n = 1'b1;
				end
				PH_P1: if (elapsed) begin
					scl_n = 1'b1; sda_n = 1'b1; phase_n = PH_P2;
				end
				PH_P2: if (elapsed) begin
					phase_n = PH_IDLE; done_n = 1'b1;
				end
				PH_W_LOW: if (elapsed) begin
					scl_n = 1'b1; phase_n = PH_W_HIGH;
				end
				PH_W_HIGH: if (elapsed) begin
					scl_n = 1'b0; bit_cnt_n = bit_inc; shift_n = shift_sh;
					if (bit_inc >= BitsPerByte) begin
						phase_n = PH_IDLE; done_n = 1'b1;
					end else begin
						sda_n = shift_sh[7]; phase_n = PH_W_LOW;
					end
				end
				PH_R_LOW: if (elapsed) begin
					scl_n = 1'b1; shift_n = {shift_q[6:0], cmd.sda_in}; phase_n = PH_R_HIGH;
				end
				PH_R_HIGH: if (elapsed) begin
					scl_n = 1'b0; bit_cnt_n = bit_inc;
					if (bit_inc >= BitsPerByte) begin
						// byte complete: drive the ACK/NACK level for the ack clock
						rx_hold_n = shift_q; drive_n = 1'b1; sda_n = !ack_send_q;
						phase_n = PH_RA_LOW;
					end else begin
						phase_n = PH_R_LOW;
					end
				end
				PH_RA_LOW: if (elapsed) begin
					scl_n = 1'b1; phase_n = PH_RA_HIGH;
				end
				PH_RA_HIGH: if (elapsed) begin
					scl_n = 1'b0; phase_n = PH_IDLE; done_n = 1'b1;
				end
				PH_A_SETTLE: if (elapsed) begin
					phase_n = PH_A_POLL;
				end
				PH_A_POLL: begin
					if (!cmd.sda_in) begin
						scl_n = 1'b0; ack_flag_n = 1'b1; phase_n = PH_IDLE; done_n = 1'b1;
					end else if (poll_q >= poll_limit_q) begin
						// timeout: flag now, then run a stop condition
						tmo_n = 1'b1; drive_n = 1'b1; scl_n = 1'b0; sda_n = 1'b0;
						delay_n = 8'd0; phase_n = PH_P1;
					end else begin
						poll_n = poll_q + 10'd1;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_cnt_q   <= 4'd0;
			shift_q     <= 8'd0;
			delay_q     <= 8'd0;
			poll_q      <= 10'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			drive_q     <= 1'b1;
			ack_flag_q  <= 1'b0;
			ack_send_q  <= 1'b0;
			rx_hold_q   <= 8'd0;
			tmo_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_n;
				bit_cnt_q  <= bit_cnt_n;
				shift_q    <= shift_n;
				delay_q    <= delay_n;
				poll_q     <= poll_n;
				scl_q      <= scl_n;
				sda_q      <= sda_n;
				drive_q    <= drive_n;
				ack_flag_q <= ack_flag_n;
				ack_send_q <= ack_send_n;
				rx_hold_q  <= rx_hold_n;
				tmo_q      <= tmo_n;
			end
			if (accept) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload register, loaded with the post-request state
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.scl_level <= scl_n;
			res_q.sda_level <= sda_n;
			res_q.sda_drive <= drive_n;
			res_q.busy_res  <= (phase_n != PH_IDLE);
			res_q.done_res  <= done_n;
			res_q.rx_byte   <= rx_hold_n;
			res_q.ack_ok    <= ack_flag_n;
			res_q.timed_out <= tmo_n;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb_i2c_bitbang_master_top.sv @@
// Self-checking bench for the bit-level I2C master: random and directed command/tick
// streams, a cycle-free predictor of pin levels and flags, in-order result compare.
// Depends on i2cbb_pkg and i2c_bitbang_master_top.
module tb_i2c_bitbang_master_top;
	import i2cbb_pkg::*;

	// ops the block must ignore, like a tick in idle
	localparam logic [2:0] OpUnused6 = 3'd6;
	localparam logic [2:0] OpUnused7 = 3'd7;
	// cycles with no request or result moving before we give up
	localparam int StallLimit = 1000;
	// cycles of quiet after the last result before config writes or the end
	localparam int SettleCycles = 4;
	// long receiver hold-off that backs the block up into its input
	localparam int ParkCycles = 80;

	typedef enum {SDA_LOW, SDA_HIGH, SDA_ANY} sda_pick_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	cmd_t                 cmd = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	res_t                 res;
	logic                 cfg_we = 1'b0;
	reg_idx_t             cfg_idx = REG_BIT_HALF;
	logic [CfgDataW-1:0]  cfg_wdata = '0;

	i2c_bitbang_master_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predicted master state and its copy of the timing registers
	// ------------------------------------------------------------------
	phase_t     ph;
	logic [3:0] bit_cnt;
	logic [7:0] shreg, dly, rx_q;
	logic [9:0] polls;
	logic       scl_q, sda_q, drv_q, ack_q, ack_send, tmo_q;
	logic [7:0] cfg_bh, cfg_ss;
	logic [9:0] cfg_poll;

	cmd_t cmd_backlog[$];     // requests waiting for the driver
	res_t expected_pins[$];   // predicted results, oldest first

	int items_queued = 0;
	int items_checked = 0;
	int errors = 0;
	int stall_cycles = 0;
	int send_gap = 0;
	int hold_left = 0;
	int park_at = 32'h7fff_ffff;
	bit parked = 1'b0;
	bit calm = 1'b0;          // no idling on either side
	bit cmd_took = 1'b0;

	function automatic void reset_master();
		cfg_bh = BitHalfReset;
		cfg_ss = StartStopReset;
		cfg_poll = PollLimitReset;
		ph = PH_IDLE;
		bit_cnt = '0;
		shreg = '0;
		dly = '0;
		polls = '0;
		scl_q = 1'b1;
		sda_q = 1'b1;
		drv_q = 1'b1;
		ack_q = 1'b0;
		ack_send = 1'b0;
		rx_q = '0;
		tmo_q = 1'b0;
	endfunction

	// one tick of a timed phase; true when the phase has run its length
	// (a zero register behaves as one tick)
	function automatic logic half_done(input logic [7:0] lim);
		dly = dly + 8'd1;
		if (dly >= lim) begin
			dly = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void launch_stop();
		drv_q = 1'b1;
		scl_q = 1'b0;
		sda_q = 1'b0;
		dly = '0;
		ph = PH_P1;
	endfunction

	// advance the predicted master by one request, return the pin/flag result
	function automatic res_t advance_master(input cmd_t c);
		res_t r;
		logic fin;
		fin = 1'b0;
		if (c.op != OP_TICK && c.op <= OP_WACK) begin
			// commands only launch from idle, dropped while busy
			if (ph == PH_IDLE) begin
				dly = '0;
				case (c.op)
					OP_START: begin
						drv_q = 1'b1;
						scl_q = 1'b1;
						sda_q = 1'b1;
						ph = PH_S1;
					end
					OP_STOP: launch_stop();
					OP_WRITE: begin
						drv_q = 1'b1;
						scl_q = 1'b0;
						bit_cnt = '0;
						shreg = c.data_byte;
						sda_q = shreg[7];
						ph = PH_W_LOW;
					end
					OP_READ: begin
						drv_q = 1'b0;
						scl_q = 1'b0;
						bit_cnt = '0;
						shreg = '0;
						ack_send = c.send_ack;
						ph = PH_R_LOW;
					end
					default: begin
						drv_q = 1'b0;
						scl_q = 1'b1;
						polls = '0;
						ack_q = 1'b0;
						tmo_q = 1'b0;
						ph = PH_A_SETTLE;
					end
				endcase
			end
		end else if (c.op == OP_TICK && ph != PH_IDLE) begin
			case (ph)
				PH_S1: if (half_done(cfg_ss)) begin
					sda_q = 1'b0;
					ph = PH_S2;
				end
				PH_S2: if (half_done(cfg_ss)) begin
					scl_q = 1'b0;
					ph = PH_IDLE;
					fin = 1'b1;
				end
				PH_P1: if (half_done(cfg_ss)) begin
					scl_q = 1'b1;
					sda_q = 1'b1;
					ph = PH_P2;
				end
				PH_P2: if (half_done(cfg_ss)) begin
					ph = PH_IDLE;
					fin = 1'b1;
				end
				PH_W_LOW: if (half_done(cfg_bh)) begin
					scl_q = 1'b1;
					ph = PH_W_HIGH;
				end
				PH_W_HIGH: if (half_done(cfg_bh)) begin
					scl_q = 1'b0;
					bit_cnt = bit_cnt + 4'd1;
					shreg = {shreg[6:0], 1'b0};
					if (bit_cnt >= BitsPerByte) begin
						ph = PH_IDLE;
						fin = 1'b1;
					end else begin
						sda_q = shreg[7];
						ph = PH_W_LOW;
					end
				end
				PH_R_LOW: if (half_done(cfg_bh)) begin
					// data bit sampled on the tick that raises SCL
					scl_q = 1'b1;
					shreg = {shreg[6:0], c.sda_in};
					ph = PH_R_HIGH;
				end
				PH_R_HIGH: if (half_done(cfg_bh)) begin
					scl_q = 1'b0;
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt >= BitsPerByte) begin
						rx_q = shreg;
						drv_q = 1'b1;
						sda_q = ~ack_send;
						ph = PH_RA_LOW;
					end else begin
						ph = PH_R_LOW;
					end
				end
				PH_RA_LOW: if (half_done(cfg_bh)) begin
					scl_q = 1'b1;
					ph = PH_RA_HIGH;
				end
				PH_RA_HIGH: if (half_done(cfg_bh)) begin
					scl_q = 1'b0;
					ph = PH_IDLE;
					fin = 1'b1;
				end
				PH_A_SETTLE: if (half_done(cfg_bh)) begin
					ph = PH_A_POLL;
				end
				PH_A_POLL: begin
					if (!c.sda_in) begin
						scl_q = 1'b0;
						ack_q = 1'b1;
						ph = PH_IDLE;
						fin = 1'b1;
					end else if (polls >= cfg_poll) begin
						// limit + 1 failing polls: flag at once, then stop
						tmo_q = 1'b1;
						launch_stop();
					end else begin
						polls = polls + 10'd1;
					end
				end
				default: ph = PH_IDLE;
			endcase
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.sda_drive = drv_q;
		r.busy_res = (ph != PH_IDLE);
		r.done_res = fin;
		r.rx_byte = rx_q;
		r.ack_ok = ack_q;
		r.timed_out = tmo_q;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	task automatic compare_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want)
			flag_error($sformatf("result %0d %s: expected %0h actual %0h",
				items_checked, name, want, got));
	endtask

	// ------------------------------------------------------------------
	// Monitor: predict on request accept, check on result accept.
	// Everything here samples at the rising edge.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		res_t want;
		cmd_took = 1'b0;
		if (!arst_n) begin
			reset_master();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_BIT_HALF:   cfg_bh = cfg_wdata[7:0];
					REG_START_STOP: cfg_ss = cfg_wdata[7:0];
					REG_POLL_LIMIT: cfg_poll = cfg_wdata;
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				expected_pins.push_back(advance_master(cmd));
				cmd_took = 1'b1;
			end
			if (res_valid && res_ready) begin
				if (expected_pins.size() == 0) begin
					flag_error($sformatf("result with no request pending: %0h", res));
				end else begin
					want = expected_pins.pop_front();
					compare_field("scl_level", 8'(want.scl_level), 8'(res.scl_level));
					compare_field("sda_level", 8'(want.sda_level), 8'(res.sda_level));
					compare_field("sda_drive", 8'(want.sda_drive), 8'(res.sda_drive));
					compare_field("busy_res", 8'(want.busy_res), 8'(res.busy_res));
					compare_field("done_res", 8'(want.done_res), 8'(res.done_res));
					compare_field("rx_byte", want.rx_byte, res.rx_byte);
					compare_field("ack_ok", 8'(want.ack_ok), 8'(res.ack_ok));
					compare_field("timed_out", 8'(want.timed_out), 8'(res.timed_out));
				end
				items_checked++;
			end
			if (cmd_took || (res_valid && res_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// ------------------------------------------------------------------
	// Request driver: falling edge, holds valid and payload until taken,
	// random gaps between requests unless calm.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (!cmd_valid || cmd_took) begin
			if (send_gap != 0) begin
				send_gap--;
				cmd_valid <= 1'b0;
			end else if (cmd_backlog.size() != 0) begin
				cmd <= cmd_backlog.pop_front();
				cmd_valid <= 1'b1;
				if (!calm && $urandom_range(0, 9) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, plus one long park that fills the
	// result register and pushes back on the request side.
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else if (!parked && items_checked >= park_at) begin
			parked = 1'b1;
			hold_left = ParkCycles - 1;
			res_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			hold_left = $urandom_range(0, 9);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// Watchdog: nothing moving for too long means a hang
	initial begin
		@(posedge arst_n);
		while (stall_cycles < StallLimit)
			@(negedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_cmd(input logic [2:0] op, input logic [7:0] data,
		input logic sack, input logic sda);
		cmd_t c;
		c.op = op;
		c.data_byte = data;
		c.send_ack = sack;
		c.sda_in = sda;
		cmd_backlog.push_back(c);
		items_queued++;
	endtask

	// n ticks; with busy_noise a few stray commands ride along (the block
	// is mid-sequence, so they must be dropped)
	task automatic queue_ticks(input int n, input sda_pick_t sda_mode, input bit busy_noise);
		int i;
		logic s;
		for (i = 0; i < n; i++) begin
			if (busy_noise && $urandom_range(0, 23) == 0)
				queue_cmd(3'($urandom_range(OP_START, OpUnused7)),
					8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			case (sda_mode)
				SDA_LOW:  s = 1'b0;
				SDA_HIGH: s = 1'b1;
				default:  s = 1'($urandom_range(0, 1));
			endcase
			queue_cmd(OP_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
		end
	endtask

	function automatic int ticks_of(input logic [7:0] v);
		return (v == 0) ? 1 : int'(v);
	endfunction

	// a complete command with exactly the ticks it needs, then a few idle ticks
	task automatic queue_sequence(input logic [2:0] op, input logic [7:0] data, input int misses);
		int bh, ss;
		bh = ticks_of(cfg_bh);
		ss = ticks_of(cfg_ss);
		queue_cmd(op, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		case (op)
			OP_START, OP_STOP: queue_ticks(2 * ss, SDA_ANY, 1'b1);
			OP_WRITE: queue_ticks(16 * bh, SDA_ANY, 1'b1);
			OP_READ: queue_ticks(18 * bh, SDA_ANY, 1'b1);
			default: begin
				queue_ticks(bh, SDA_ANY, 1'b1);
				if (misses > int'(cfg_poll)) begin
					// poll limit exceeded: timeout and automatic stop
					queue_ticks(int'(cfg_poll) + 1, SDA_HIGH, 1'b1);
					queue_ticks(2 * ss, SDA_ANY, 1'b1);
				end else begin
					queue_ticks(misses, SDA_HIGH, 1'b1);
					queue_ticks(1, SDA_LOW, 1'b1);
				end
			end
		endcase
		queue_ticks($urandom_range(0, 2), SDA_ANY, 1'b0);
	endtask

	// enough low-SDA ticks to bring any sequence back to idle
	task automatic queue_recovery();
		queue_ticks(18 * ticks_of(cfg_bh) + 2 * ticks_of(cfg_ss) + 2, SDA_LOW, 1'b0);
	endtask

	task automatic queue_random(input int n);
		int goal, pick, misses;
		logic [7:0] data;
		goal = items_queued + n;
		while (items_queued < goal) begin
			pick = $urandom_range(0, 99);
			case ($urandom_range(0, 5))
				0: data = 8'h00;
				1: data = 8'hFF;
				default: data = 8'($urandom_range(0, 255));
			endcase
			case ($urandom_range(0, 3))
				0: misses = 0;
				1: misses = (cfg_poll <= 40) ? int'(cfg_poll) : 5;
				2: misses = (cfg_poll <= 40) ? int'(cfg_poll) + 1 : 7;
				default: misses = $urandom_range(0, 12);
			endcase
			if (pick < 20) begin
				queue_sequence(OP_WRITE, data, 0);
			end else if (pick < 40) begin
				queue_sequence(OP_READ, data, 0);
			end else if (pick < 60) begin
				queue_sequence(OP_WACK, data, misses);
			end else if (pick < 72) begin
				queue_sequence(OP_START, data, 0);
			end else if (pick < 84) begin
				queue_sequence(OP_STOP, data, 0);
			end else if (pick < 92) begin
				// cut short: command, a few ticks, then recover
				queue_cmd(3'($urandom_range(OP_START, OP_WACK)), data,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				queue_ticks($urandom_range(0, 6), SDA_ANY, 1'b1);
				queue_recovery();
			end else begin
				// raw noise over the whole op space, including unused codes
				repeat ($urandom_range(1, 6))
					queue_cmd(3'($urandom_range(OP_TICK, OpUnused7)), data,
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				queue_recovery();
			end
		end
		queue_recovery();
	endtask

	// wait until every queued request has its result checked, then let the
	// registered result pipe settle; ends on a falling edge
	task automatic drain_all();
		do @(negedge clk); while (items_checked != items_queued);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// all three timing registers, one write per cycle; called at a falling edge
	task automatic set_regs(input logic [7:0] bh, input logic [7:0] ss, input logic [9:0] lim);
		cfg_idx <= REG_BIT_HALF;
		cfg_wdata <= CfgDataW'(bh);
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_idx <= REG_START_STOP;
		cfg_wdata <= CfgDataW'(ss);
		@(negedge clk);
		cfg_idx <= REG_POLL_LIMIT;
		cfg_wdata <= lim;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		int p;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset timing values: unused ops, idle tick, stop, ack
		queue_cmd(OpUnused6, 8'hFF, 1'b1, 1'b1);
		queue_cmd(OpUnused7, 8'h00, 1'b0, 1'b0);
		queue_cmd(OP_TICK, 8'h5A, 1'b1, 1'b1);
		queue_sequence(OP_STOP, 8'h00, 0);
		queue_sequence(OP_WACK, 8'h00, 0);
		drain_all();

		// Directed, zero registers: one tick per phase, timeout on the first
		// failing poll, command dropped while busy, ack on the first poll
		set_regs(8'd0, 8'd0, 10'd0);
		queue_sequence(OP_WACK, 8'h00, 1);
		queue_cmd(OP_START, 8'h00, 1'b0, 1'b1);
		queue_cmd(OP_READ, 8'hFF, 1'b1, 1'b0);
		queue_ticks(2, SDA_ANY, 1'b0);
		queue_sequence(OP_WACK, 8'h00, 0);
		queue_random(60);
		drain_all();

		// Largest timings: kept to a few sequences since each phase is long
		set_regs(8'd255, 8'd255, 10'd1023);
		queue_sequence(OP_START, 8'h00, 0);
		queue_sequence(OP_WACK, 8'h00, 3);
		drain_all();

		// Random phases, small timings so sequences stay short; the second
		// one parks the receiver, the last one runs with no idling at all
		for (p = 0; p < 6; p++) begin
			case (p)
				0: set_regs(8'd1, 8'd1, 10'd1);
				1: set_regs(8'd2, 8'd4, 10'd250);
				default: set_regs(8'($urandom_range(1, 3)), 8'($urandom_range(1, 4)),
					10'($urandom_range(0, 8)));
			endcase
			if (p == 1)
				park_at = items_queued + 30;
			if (p == 5)
				calm = 1'b1;
			queue_random(60);
			drain_all();
		end

		errors += expected_pins.size();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ i2c_bitbang_master_top.f @@
sv/i2cbb_pkg.sv
sv/i2c_bitbang_master_top.sv
tb/sv/tb_i2c_bitbang_master_top.sv
